// ----- rtl/idll_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types, codes and widths for the indexed doubly linked list block.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int ID_W          = 10;
  localparam int LINK_W        = 11;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int NODES_DEFAULT = 1024;

  // link value meaning "no neighbor"
  localparam logic [LINK_W-1:0] LINK_NONE = 11'd1024;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INS_BEFORE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_AFTER  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ANCHOR_ABSENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TARGET_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TARGET_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SENTINEL       = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   anchor_id;
    logic [ID_W-1:0]   target_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                present;
    logic [LINK_W-1:0]   prev_id;
    logic [LINK_W-1:0]   next_id;
  } rsp_t;

  // classified operation, as queued between front and back
  typedef struct packed {
    logic            ins;         // insert before or after
    logic            after;       // insert after (else before)
    logic            del;
    logic            qry;
    logic            anchor_in;   // anchor id below NODES
    logic            target_in;   // target id below NODES
    logic            target_zero; // target is the sentinel
    logic [ID_W-1:0] anchor;
    logic [ID_W-1:0] target;
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/idll_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idll_ram
// Generic single-port RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                      wdata,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/idll_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idll_front
// Accepts requests, decodes the operation and id ranges, and queues the
// classified operation for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module idll_front #(
  parameter int NODES = idll_pkg::NODES_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire idll_pkg::req_t  req,
  input  wire logic            hold,     // back end is clearing
  output logic                 q_valid,
  output idll_pkg::op_t        q_item,
  input  wire logic            q_pop
);

  idll_pkg::op_t entries [2];
  idll_pkg::op_t cls;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;

  always_comb begin
    cls.ins = (req.func == idll_pkg::FUNC_INS_BEFORE) ||
              (req.func == idll_pkg::FUNC_INS_AFTER);
    cls.after       = (req.func == idll_pkg::FUNC_INS_AFTER);
    cls.del         = (req.func == idll_pkg::FUNC_DELETE);
    cls.qry         = (req.func == idll_pkg::FUNC_QUERY);
    cls.anchor_in   = 32'(req.anchor_id) < 32'(NODES);
    cls.target_in   = 32'(req.target_id) < 32'(NODES);
    cls.target_zero = (req.target_id == '0);
    cls.anchor      = req.anchor_id;
    cls.target      = req.target_id;
  end

  assign req_stall = (count == 2'd2) || hold;
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != 2'd0);
  assign q_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/idll_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idll_back
// Executes queued operations against the link and presence RAMs and holds
// the result register. Also runs the presence clearing pass after reset.
// ----------------------------------------------------------------------------
module idll_back #(
  parameter int NODES = idll_pkg::NODES_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire idll_pkg::op_t  q_item,
  output logic                q_pop,
  output logic                clearing,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output idll_pkg::rsp_t      rsp
);

  localparam int ADDR_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int ID_EXT_W = (ADDR_W > idll_pkg::ID_W) ? ADDR_W : idll_pkg::ID_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD_A  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_W1    = 3'd4;
  localparam logic [2:0] S_W2    = 3'd5;
  localparam logic [2:0] S_WD    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [idll_pkg::ID_W-1:0] id);
    logic [ID_EXT_W-1:0] ext;
    ext = ID_EXT_W'(id);
    return ext[ADDR_W-1:0];
  endfunction

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [ADDR_W-1:0]             clr_addr;
  idll_pkg::op_t                 op;
  logic                          t_pres;
  logic [idll_pkg::LINK_W-1:0]   t_pred;
  logic [idll_pkg::LINK_W-1:0]   t_succ;
  logic [idll_pkg::LINK_W-1:0]   nb;      // anchor's old neighbor on insert side
  idll_pkg::rsp_t                res;
  idll_pkg::rsp_t                res_next;
  logic [idll_pkg::LINK_W-1:0]   nb_next;
  logic                          load;

  logic                          pred_we, succ_we, pres_we;
  logic [ADDR_W-1:0]             pred_addr, succ_addr, pres_addr;
  logic [idll_pkg::LINK_W-1:0]   pred_wdata, succ_wdata;
  logic [idll_pkg::LINK_W-1:0]   pred_rdata, succ_rdata;
  logic                          pres_wdata, pres_rdata;

  logic [idll_pkg::LINK_W-1:0]   anchor_link, target_link;
  logic                          a_pres;

  assign anchor_link = {1'b0, op.anchor};
  assign target_link = {1'b0, op.target};
  assign a_pres      = pres_rdata && op.anchor_in;

  idll_ram #(.WIDTH(idll_pkg::LINK_W), .DEPTH(NODES)) u_pred_ram (
    .clk(clk), .we(pred_we), .addr(pred_addr), .wdata(pred_wdata), .rdata(pred_rdata)
  );

  idll_ram #(.WIDTH(idll_pkg::LINK_W), .DEPTH(NODES)) u_succ_ram (
    .clk(clk), .we(succ_we), .addr(succ_addr), .wdata(succ_wdata), .rdata(succ_rdata)
  );

  idll_ram #(.WIDTH(1), .DEPTH(NODES)) u_pres_ram (
    .clk(clk), .we(pres_we), .addr(pres_addr), .wdata(pres_wdata), .rdata(pres_rdata)
  );

  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign load     = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // RAM port steering
  always_comb begin
    pred_we    = 1'b0;
    succ_we    = 1'b0;
    pres_we    = 1'b0;
    pred_addr  = to_addr(op.target);
    succ_addr  = to_addr(op.target);
    pres_addr  = to_addr(op.target);
    pred_wdata = target_link;
    succ_wdata = target_link;
    pres_wdata = 1'b1;
    case (state)
      S_CLEAR: begin
        pres_we    = 1'b1;
        pres_addr  = clr_addr;
        pres_wdata = (clr_addr == '0);
        // sentinel starts with no neighbors
        pred_we    = (clr_addr == '0);
        succ_we    = (clr_addr == '0);
        pred_addr  = clr_addr;
        succ_addr  = clr_addr;
        pred_wdata = idll_pkg::LINK_NONE;
        succ_wdata = idll_pkg::LINK_NONE;
      end
      S_IDLE: begin
        pred_addr = to_addr(q_item.target);
        succ_addr = to_addr(q_item.target);
        pres_addr = to_addr(q_item.target);
      end
      S_RD_A: begin
        pred_addr = to_addr(op.anchor);
        succ_addr = to_addr(op.anchor);
        pres_addr = to_addr(op.anchor);
      end
      S_W1: begin
        pred_we    = 1'b1;
        succ_we    = 1'b1;
        pres_we    = 1'b1;
        pred_wdata = op.after ? anchor_link : nb;
        succ_wdata = op.after ? nb : anchor_link;
      end
      S_W2: begin
        if (op.after) begin
          succ_we   = 1'b1;
          succ_addr = to_addr(op.anchor);
          pred_we   = (nb != idll_pkg::LINK_NONE);
          pred_addr = to_addr(nb[idll_pkg::ID_W-1:0]);
        end else begin
          pred_we   = 1'b1;
          pred_addr = to_addr(op.anchor);
          succ_we   = (nb != idll_pkg::LINK_NONE);
          succ_addr = to_addr(nb[idll_pkg::ID_W-1:0]);
        end
      end
      S_WD: begin
        succ_we    = (t_pred != idll_pkg::LINK_NONE);
        succ_addr  = to_addr(t_pred[idll_pkg::ID_W-1:0]);
        succ_wdata = t_succ;
        pred_we    = (t_succ != idll_pkg::LINK_NONE);
        pred_addr  = to_addr(t_succ[idll_pkg::ID_W-1:0]);
        pred_wdata = t_pred;
        pres_we    = 1'b1;
        pres_wdata = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // next state, and evaluation of the operation once target and anchor links are in hand
  always_comb begin
    state_next = state;
    res_next   = res;
    nb_next    = nb;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(NODES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_RD_A;
        end
      end
      S_RD_A: state_next = S_EVAL;
      S_EVAL: begin
        res_next.status  = idll_pkg::ST_OK;
        res_next.present = t_pres;
        res_next.prev_id = t_pres ? t_pred : idll_pkg::LINK_NONE;
        res_next.next_id = t_pres ? t_succ : idll_pkg::LINK_NONE;
        state_next       = S_DONE;
        if (op.ins) begin
          if (!a_pres) begin
            res_next.status = idll_pkg::ST_ANCHOR_ABSENT;
          end else if (!op.target_in) begin
            res_next.status = idll_pkg::ST_TARGET_ABSENT;
          end else if (t_pres) begin
            res_next.status = idll_pkg::ST_TARGET_PRESENT;
          end else begin
            nb_next          = op.after ? succ_rdata : pred_rdata;
            res_next.present = 1'b1;
            res_next.prev_id = op.after ? anchor_link : pred_rdata;
            res_next.next_id = op.after ? succ_rdata : anchor_link;
            state_next       = S_W1;
          end
        end else if (op.del) begin
          if (op.target_zero) begin
            res_next.status = idll_pkg::ST_SENTINEL;
          end else if (!t_pres) begin
            res_next.status = idll_pkg::ST_TARGET_ABSENT;
          end else begin
            res_next.present = 1'b0;
            res_next.prev_id = idll_pkg::LINK_NONE;
            res_next.next_id = idll_pkg::LINK_NONE;
            state_next       = S_WD;
          end
        end else if (!t_pres) begin
          res_next.status = idll_pkg::ST_TARGET_ABSENT;
        end
      end
      S_W1:   state_next = S_W2;
      S_W2:   state_next = S_DONE;
      S_WD:   state_next = S_DONE;
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op <= q_item;
    end
    if (state == S_RD_A) begin
      t_pres <= pres_rdata && op.target_in;
      t_pred <= pred_rdata;
      t_succ <= succ_rdata;
    end
    res <= res_next;
    nb  <= nb_next;
    if (load) begin
      rsp <= res;
    end
  end

  // no item leaves the queue during the clearing pass
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !q_pop)
    else $error("item popped during clearing pass");

  // link and presence RAMs are only written in write states or clearing
  a_no_early_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RD_A || state == S_EVAL || state == S_DONE)
      |-> !(pred_we || succ_we || pres_we))
    else $error("RAM write outside a write state");

  // a pop always starts the anchor read next cycle
  a_pop_seq: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_RD_A))
    else $error("sequencer skipped the anchor read");

  // a successful insert reports the target as present
  a_ins_present: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && op.ins && res.status == idll_pkg::ST_OK) |-> res.present)
    else $error("successful insert reports absent target");

  // refused operations and queries report presence as it was read
  a_refused_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (op.qry || res.status != idll_pkg::ST_OK))
      |-> (res.present == t_pres))
    else $error("refused operation changed reported presence");

endmodule

`default_nettype wire

// ----- rtl/indexed_doubly_linked_list_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top
// Doubly linked list held as predecessor/successor RAMs indexed by node id,
// node 0 a permanent head sentinel. Insert before/after, delete, query.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                      | Dir | Transfer when
//  --------+------------------------------+-----+---------------------------
//  req     | req_valid, req_stall, req    | in  | req_valid && !req_stall
//  rsp     | rsp_valid, rsp_stall, rsp    | out | rsp_valid && !rsp_stall
//
//  Sequencing: one operation at a time in the back end. After a queue pop
//  the target links are read, then the anchor's; the operation is decided,
//  then an insert writes in S_W1 and S_W2, a delete in S_WD, and S_DONE
//  loads the result register. The order is set by the single-port RAMs.
//  Reset: after rst the presence RAM is swept, one entry a cycle, over all
//  NODES entries; req_stall is high for the whole pass.
//  Stalls: a two-entry queue parts the front from the back end, and the
//  result register lets the back end finish while rsp is stalled; it waits
//  only when a finished result still sits in the register.
//
//  Refused operations (absent anchor, target already present, deleting the
//  sentinel or an absent target) leave the tables alone and report the
//  target's presence and links as they stand.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_top #(
  parameter int NODES = idll_pkg::NODES_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire idll_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output idll_pkg::rsp_t       rsp
);

  // front-to-back queue interface
  logic          q_valid;
  idll_pkg::op_t q_item;
  logic          q_pop;
  logic          clearing;

  // front: decode ids and function, buffer up to two transfers
  idll_front #(.NODES(NODES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .hold      (clearing),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back: read links, decide, write links, register the result
  idll_back #(.NODES(NODES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
